### rtl/core/itoa_pkg.sv
// shared types, constants and elaboration-time helpers for the signed integer to
// decimal ascii converter; no dependencies
package itoa_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int DIGIT_W         = 4;

    localparam logic [7:0] MINUS_CHAR = 8'h2D;
    localparam logic [7:0] ZERO_CHAR  = 8'h30;

    // per-cycle command from the sequencer to every bcd cell
    typedef struct packed {
        logic clear;   // zero the digit
        logic dabble;  // add-3 correct, then shift one bit in from below
        logic move;    // take the lower neighbor's digit (shift toward msd)
    } itoa_cell_ctl_t;

    // decimal digits needed for the largest magnitude, 2^(w-1)
    function automatic int dec_digits(input int w);
        longint unsigned v;
        int              n;
        v = longint'(1) << (w - 1);
        n = 0;
        while (v != 0) begin
            v = v / 10;
            n = n + 1;
        end
        return n;
    endfunction

endpackage

### rtl/core/signed_int_to_decimal_ascii_core.sv
// top level of the signed integer to decimal ascii converter: sequencer plus
// a row of itoa_cell bcd digit cells; depends on itoa_pkg and itoa_cell
//
// usage:
//   slave side (s_tvalid/s_tready/s_tdata) takes one signed two's complement
//   value per beat in s_tdata[VALUE_WIDTH-1:0]; padding bits above are ignored.
//   master side (m_tvalid/m_tready/m_tdata/m_tlast) gives one ascii character
//   per beat, most significant first: an optional '-', then the digits with
//   leading zeros dropped; m_tlast marks the final digit. zero gives one '0'.
// timing:
//   a value is shifted through the digit cells one bit per cycle after the
//   accepting edge. leading zero cells are then skipped at one per cycle (up
//   to N_DIG-1), and characters leave at one per cycle while m_tready is
//   high. one value is in work at a time; s_tready is high only while idle.
// reset and stall:
//   reset returns the sequencer to idle and empties the output register.
//   when m_tready is low the character holds in the output register and the
//   sequencer waits; nothing is dropped.
module signed_int_to_decimal_ascii_core #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_tdata,   // [VALUE_WIDTH-1:0] number
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [7:0] character
    output logic                                m_tlast    // last_char
);
    import itoa_pkg::*;

    localparam int N_DIG = dec_digits(VALUE_WIDTH);
    localparam int BW    = $clog2(VALUE_WIDTH + 1);
    localparam int DW    = $clog2(N_DIG + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [BW-1:0]          bit_cnt_reg, bit_cnt_next;
    logic [DW-1:0]          dig_cnt_reg, dig_cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             out_data_reg, out_data_next;
    logic                   out_last_reg, out_last_next;

    itoa_cell_ctl_t         ctl;
    logic [VALUE_WIDTH-1:0] number;
    logic                   out_free;
    logic [3:0]             top_digit;

    logic [3:0]             digit_w [N_DIG];
    logic                   carry_w [N_DIG];

    // row of digit cells, least significant at index 0
    for (genvar i = 0; i < N_DIG; i++)
    begin : g_cell
        if (i == 0)
        begin : g_lsd
            itoa_cell u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .bit_in   (mag_reg[VALUE_WIDTH-1]),
                .digit_in (4'd0),
                .bit_out  (carry_w[i]),
                .digit    (digit_w[i])
            );
        end
        else
        begin : g_upper
            itoa_cell u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .bit_in   (carry_w[i-1]),
                .digit_in (digit_w[i-1]),
                .bit_out  (carry_w[i]),
                .digit    (digit_w[i])
            );
        end
    end

    assign number    = s_tdata[VALUE_WIDTH-1:0];
    assign top_digit = digit_w[N_DIG-1];
    assign out_free  = !out_valid_reg || m_tready;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tlast   = out_last_reg;

    // sequencer next state and cell commands
    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        ctl            = '0;

        // output beat taken
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    neg_next     = number[VALUE_WIDTH-1];
                    mag_next     = number[VALUE_WIDTH-1] ?
                                   VALUE_WIDTH'(~number + 1'b1) : number;
                    bit_cnt_next = BW'(VALUE_WIDTH);
                    ctl.clear    = 1'b1;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                ctl.dabble   = 1'b1;
                mag_next     = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == BW'(1))
                begin
                    dig_cnt_next = DW'(N_DIG);
                    state_next   = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zero digits, keep at least one
                if (top_digit == 4'd0 && dig_cnt_reg > DW'(1))
                begin
                    ctl.move     = 1'b1;
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = MINUS_CHAR;
                    out_last_next  = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = ZERO_CHAR + {4'd0, top_digit};
                    out_last_next  = (dig_cnt_reg == DW'(1));
                    ctl.move       = 1'b1;
                    dig_cnt_next   = dig_cnt_reg - 1'b1;
                    if (dig_cnt_reg == DW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mag_reg       <= mag_next;
            neg_reg       <= neg_next;
            bit_cnt_reg   <= bit_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_last_reg  <= out_last_next;
        end
    end

endmodule

### rtl/core/itoa_cell.sv
// one bcd digit cell of the double-dabble chain
// depends on itoa_pkg for the control struct and digit width
module itoa_cell (
    input  logic                    clk,
    input  itoa_pkg::itoa_cell_ctl_t ctl,
    input  logic                    bit_in,
    input  logic [3:0]              digit_in,
    output logic                    bit_out,
    output logic [3:0]              digit
);
    import itoa_pkg::*;

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] adjusted;

    // add-3 correction before each shift
    assign adjusted = (digit_reg >= DIGIT_W'(5)) ? digit_reg + DIGIT_W'(3) : digit_reg;
    assign bit_out  = adjusted[DIGIT_W-1];
    assign digit    = digit_reg;

    // next digit by command
    always_comb
    begin
        digit_next = digit_reg;
        if (ctl.clear)
        begin
            digit_next = '0;
        end
        else if (ctl.dabble)
        begin
            digit_next = {adjusted[DIGIT_W-2:0], bit_in};
        end
        else if (ctl.move)
        begin
            digit_next = digit_in;
        end
    end

    // digit storage
    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule
